[rtl/core/bsfr_pkg.sv]
// Package for the byte-stuffed frame receiver: queue sizes, codes and the
// item, result and configuration types. No dependencies.
package bsfr_pkg;

  localparam int unsigned FQ_DEPTH = 2;  // front queue entries
  localparam int unsigned RQ_DEPTH = 2;  // result queue entries

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] TIMEOUT_RST = 32'd1000;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;
  localparam logic [7:0] START_CODE_RST = 8'd1;
  localparam logic [7:0] END_CODE_RST = 8'd4;
  localparam logic [7:0] ESCAPE_CODE_RST = 8'd27;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_MS  = 3'd0,
    CFG_MAX_PAYLOAD = 3'd1,
    CFG_START_CODE  = 3'd2,
    CFG_END_CODE    = 3'd3,
    CFG_ESCAPE_CODE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2
  } rx_phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_START   = 2'd0,
    ERR_OVER    = 2'd1,
    ERR_BADESC  = 2'd2,
    ERR_TIMEOUT = 2'd3
  } err_code_e;

  typedef struct packed {
    logic [31:0] timeout_ms;
    logic [15:0] max_payload;
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  escape_code;
  } cfg_t;

  // Classified input item as held in the front queue.
  typedef struct packed {
    logic       tick;
    logic       is_start;
    logic       is_end;
    logic       is_esc;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  fault_code;
    logic [15:0] frame_length;
    logic [31:0] error_total;
  } result_t;

endpackage

[rtl/core/byte_stuffing_frame_receiver.sv]
// Byte-stuffed frame receiver: an accepted request is held in the front queue,
// then the state update writes its result to the result queue, which drives the ports.
// Throughput one request per cycle; a tick or byte is taken every cycle while
// results are popped, since the state step is one counter add and compare.
// Reset is asynchronous, active low: queues empty, idle phase, counters zero,
// registers at their defaults. No clearing pass.
module byte_stuffing_frame_receiver
  import bsfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  logic                  command_i,
  input  logic [7:0]            byte_value_i,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind_o,
  output logic [7:0]            data_byte_o,
  output logic [1:0]            fault_code_o,
  output logic [15:0]           frame_length_o,
  output logic [31:0]           error_total_o
);

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_pop;
  logic    res_push, res_full;
  result_t res_new, res_head;

  // Registers take a write in any cycle; software must write only while idle,
  // not enforced here, else queued items stay classified against a stale code.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms  <= TIMEOUT_RST;
      cfg_q.max_payload <= MAX_PAYLOAD_RST;
      cfg_q.start_code  <= START_CODE_RST;
      cfg_q.end_code    <= END_CODE_RST;
      cfg_q.escape_code <= ESCAPE_CODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TIMEOUT_MS:  cfg_q.timeout_ms  <= cfg_data_i;
        CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i[15:0];
        CFG_START_CODE:  cfg_q.start_code  <= cfg_data_i[7:0];
        CFG_END_CODE:    cfg_q.end_code    <= cfg_data_i[7:0];
        CFG_ESCAPE_CODE: cfg_q.escape_code <= cfg_data_i[7:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Front: classify each byte against the codes and hold it in a short queue.
  bsfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .command_i    (command_i),
    .byte_value_i (byte_value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back: advance the receive phase and counters, one request per cycle
  // whenever the result queue has room.
  bsfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_new)
  );

  // Result queue: hold finished results until the consumer pops them.
  bsfr_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_new),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_head)
  );

  assign kind_o         = res_head.kind;
  assign data_byte_o    = res_head.data_byte;
  assign fault_code_o   = res_head.fault_code;
  assign frame_length_o = res_head.frame_length;
  assign error_total_o  = res_head.error_total;

endmodule

[rtl/core/bsfr_front.sv]
// Front part: accepts received bytes and ticks, classifies bytes against
// the control codes and holds them in a short queue. Uses bsfr_pkg.
module bsfr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bsfr_pkg::cfg_t cfg_i,
  input  logic           push_i,
  output logic           full_o,
  input  logic           command_i,
  input  logic [7:0]     byte_value_i,
  output logic           item_valid_o,
  output bsfr_pkg::item_t item_o,
  input  logic           item_pop_i
);
  import bsfr_pkg::*;

  localparam int unsigned PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FQ_DEPTH + 1);

  item_t             mem_q [FQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  item_t             item_in;
  logic              do_push, do_pop;

  always_comb begin
    item_in.tick       = command_i;
    item_in.is_start   = (byte_value_i == cfg_i.start_code);
    item_in.is_end     = (byte_value_i == cfg_i.end_code);
    item_in.is_esc     = (byte_value_i == cfg_i.escape_code);
    item_in.byte_value = byte_value_i;
  end

  assign full_o       = (count_q == CNT_W'(FQ_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/core/bsfr_back.sv]
// Back part: runs the receive state machine, the payload, elapsed and error
// counters, and produces one result per item at most. Uses bsfr_pkg.
module bsfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsfr_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  bsfr_pkg::item_t   item_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output bsfr_pkg::result_t res_o
);
  import bsfr_pkg::*;

  rx_phase_e   phase_q, phase_d;
  logic [15:0] pcount_q, pcount_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] err_cnt_q, err_cnt_d;

  logic        go, in_frame, is_ctrl, overflow, timeout_hit;
  logic [31:0] elapsed_inc;

  assign go          = item_valid_i && !res_full_i;
  assign item_pop_o  = go;
  assign in_frame    = (phase_q == PH_FRAME) || (phase_q == PH_ESC);
  assign is_ctrl     = item_i.is_start || item_i.is_end || item_i.is_esc;
  assign overflow    = (pcount_q >= cfg_i.max_payload);
  // saturate the tick count at its maximum
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
  assign timeout_hit = (elapsed_inc > cfg_i.timeout_ms);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (go) begin
      if (item_i.tick) begin
        if (in_frame && timeout_hit) begin
          phase_d = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_FRAME: begin
            if (item_i.is_start || item_i.is_end) begin
              phase_d = PH_IDLE;
            end else if (item_i.is_esc) begin
              phase_d = PH_ESC;
            end
          end
          PH_ESC: begin
            if (is_ctrl) begin
              phase_d = PH_FRAME;
            end
          end
          default: begin
            phase_d = item_i.is_start ? PH_FRAME : PH_IDLE;
          end
        endcase
      end
    end
  end

  // results and counters
  always_comb begin
    logic take_payload;
    logic raise;
    logic [1:0] ecode;
    take_payload       = 1'b0;
    raise              = 1'b0;
    ecode              = ERR_START;
    res_push_o         = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.data_byte    = '0;
    res_o.fault_code   = ERR_START;
    res_o.frame_length = '0;
    res_o.error_total  = err_cnt_q;
    pcount_d           = pcount_q;
    elapsed_d          = elapsed_q;
    err_cnt_d          = err_cnt_q;
    if (go) begin
      if (item_i.tick) begin
        if (in_frame) begin
          elapsed_d = elapsed_inc;
          if (timeout_hit) begin
            raise = 1'b1;
            ecode = ERR_TIMEOUT;
          end
        end
      end else begin
        case (phase_q)
          PH_FRAME: begin
            if (item_i.is_start) begin
              raise = 1'b1;
              ecode = ERR_START;
            end else if (item_i.is_end) begin
              res_push_o         = 1'b1;
              res_o.kind         = KIND_DONE;
              res_o.frame_length = pcount_q;
              pcount_d           = '0;
            end else if (!item_i.is_esc) begin
              take_payload = 1'b1;
            end
          end
          PH_ESC: begin
            if (is_ctrl) begin
              take_payload = 1'b1;
            end else begin
              raise = 1'b1;
              ecode = ERR_BADESC;
            end
          end
          default: begin
            if (item_i.is_start) begin
              elapsed_d = '0;
              pcount_d  = '0;
            end
          end
        endcase
      end
      // a payload byte past the limit is dropped as an overflow
      if (take_payload) begin
        if (overflow) begin
          raise = 1'b1;
          ecode = ERR_OVER;
        end else begin
          res_push_o      = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = item_i.byte_value;
          pcount_d        = pcount_q + 16'd1;
        end
      end
      if (raise) begin
        res_push_o        = 1'b1;
        res_o.kind        = KIND_ERR;
        res_o.fault_code  = ecode;
        res_o.error_total = err_cnt_q + 32'd1;
        err_cnt_d         = err_cnt_q + 32'd1;
        pcount_d          = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pcount_q  <= '0;
      elapsed_q <= '0;
      err_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pcount_q  <= pcount_d;
      elapsed_q <= elapsed_d;
      err_cnt_q <= err_cnt_d;
    end
  end

  a_err_cnt_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_cnt_d != err_cnt_q) |-> (res_push_o && res_o.kind == KIND_ERR))
    else $error("error counter moved without an error result");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KIND_DONE) |=> (phase_q == PH_IDLE && pcount_q == '0))
    else $error("frame end did not return to idle");

  a_push_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (item_valid_i && !res_full_i))
    else $error("result pushed without a consumed item");

  a_timeout_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KIND_ERR && res_o.fault_code == ERR_TIMEOUT)
    |=> (phase_q == PH_IDLE))
    else $error("timeout did not return to idle");

endmodule

[rtl/core/bsfr_res_q.sv]
// Result queue between the back part and the consumer; the head entry drives
// the result ports. Uses bsfr_pkg.
module bsfr_res_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsfr_pkg::result_t res_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output bsfr_pkg::result_t res_o
);
  import bsfr_pkg::*;

  localparam int unsigned PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RQ_DEPTH + 1);

  result_t           mem_q [RQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(RQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  a_push_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> !empty_o)
    else $error("pushed result not visible");

endmodule
